[hdl/rmch_pkg.sv]
// rmch_pkg: shared types, constants and helpers of the closest-hit ray/triangle block
// no dependencies; imported by rmch_div, ray_mesh_closest_hit and the testbench files
package rmch_pkg;

    // mesh size and index cap
    localparam int unsigned MAX_TRIANGLES = 65536;
    localparam int unsigned IDX_CAP_I     = (MAX_TRIANGLES - 1) < 65535 ?
                                            (MAX_TRIANGLES - 1) : 65535;
    localparam logic [15:0] IDX_CAP       = IDX_CAP_I[15:0];

    // arithmetic widths
    localparam int unsigned ACC_W = 50;
    localparam logic [30:0] T_SAT = 31'h7FFF_FFFF;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_DIR_X       = 3'd3,
        CFG_DIR_Y       = 3'd4,
        CFG_DIR_Z       = 3'd5,
        CFG_DET_EPSILON = 3'd6,
        CFG_T_MIN       = 3'd7
    } t_cfg_idx;

    // operand codes of the shared multiplier
    typedef enum logic [4:0] {
        OPD_DX, OPD_DY, OPD_DZ,
        OPD_E1X, OPD_E1Y, OPD_E1Z,
        OPD_E2X, OPD_E2Y, OPD_E2Z,
        OPD_SX, OPD_SY, OPD_SZ,
        OPD_HX, OPD_HY, OPD_HZ,
        OPD_QX, OPD_QY, OPD_QZ,
        OPD_T
    } t_opd;

    // writeback targets of the accumulator
    typedef enum logic [3:0] {
        WR_NONE, WR_HX, WR_HY, WR_HZ, WR_QX, WR_QY, WR_QZ,
        WR_DET, WR_NU, WR_NV, WR_NT, WR_PX, WR_PY, WR_PZ
    } t_wr;

    // one micro-operation: multiply a by b, add or subtract, maybe write back
    typedef struct packed {
        t_opd a;
        t_opd b;
        logic neg;
        logic first;
        t_wr  wr;
    } t_uop;

    // step numbers of the sequence
    localparam logic [4:0] STEP_TRI_LAST  = 5'd23;
    localparam logic [4:0] STEP_PNT_FIRST = 5'd24;
    localparam logic [4:0] STEP_PNT_LAST  = 5'd26;

    // micro-program: h = d x e2, q = s x e1, then dot products, then hit point
    function automatic t_uop ucode(input logic [4:0] step);
        t_uop u;
        u = '{a: OPD_DX, b: OPD_DX, neg: 1'b0, first: 1'b1, wr: WR_NONE};
        case (step)
            5'd0:  u = '{a: OPD_DY,  b: OPD_E2Z, neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd1:  u = '{a: OPD_DZ,  b: OPD_E2Y, neg: 1'b1, first: 1'b0, wr: WR_HX};
            5'd2:  u = '{a: OPD_DZ,  b: OPD_E2X, neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd3:  u = '{a: OPD_DX,  b: OPD_E2Z, neg: 1'b1, first: 1'b0, wr: WR_HY};
            5'd4:  u = '{a: OPD_DX,  b: OPD_E2Y, neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd5:  u = '{a: OPD_DY,  b: OPD_E2X, neg: 1'b1, first: 1'b0, wr: WR_HZ};
            5'd6:  u = '{a: OPD_SY,  b: OPD_E1Z, neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd7:  u = '{a: OPD_SZ,  b: OPD_E1Y, neg: 1'b1, first: 1'b0, wr: WR_QX};
            5'd8:  u = '{a: OPD_SZ,  b: OPD_E1X, neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd9:  u = '{a: OPD_SX,  b: OPD_E1Z, neg: 1'b1, first: 1'b0, wr: WR_QY};
            5'd10: u = '{a: OPD_SX,  b: OPD_E1Y, neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd11: u = '{a: OPD_SY,  b: OPD_E1X, neg: 1'b1, first: 1'b0, wr: WR_QZ};
            5'd12: u = '{a: OPD_E1X, b: OPD_HX,  neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd13: u = '{a: OPD_E1Y, b: OPD_HY,  neg: 1'b0, first: 1'b0, wr: WR_NONE};
            5'd14: u = '{a: OPD_E1Z, b: OPD_HZ,  neg: 1'b0, first: 1'b0, wr: WR_DET};
            5'd15: u = '{a: OPD_SX,  b: OPD_HX,  neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd16: u = '{a: OPD_SY,  b: OPD_HY,  neg: 1'b0, first: 1'b0, wr: WR_NONE};
            5'd17: u = '{a: OPD_SZ,  b: OPD_HZ,  neg: 1'b0, first: 1'b0, wr: WR_NU};
            5'd18: u = '{a: OPD_DX,  b: OPD_QX,  neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd19: u = '{a: OPD_DY,  b: OPD_QY,  neg: 1'b0, first: 1'b0, wr: WR_NONE};
            5'd20: u = '{a: OPD_DZ,  b: OPD_QZ,  neg: 1'b0, first: 1'b0, wr: WR_NV};
            5'd21: u = '{a: OPD_E2X, b: OPD_QX,  neg: 1'b0, first: 1'b1, wr: WR_NONE};
            5'd22: u = '{a: OPD_E2Y, b: OPD_QY,  neg: 1'b0, first: 1'b0, wr: WR_NONE};
            5'd23: u = '{a: OPD_E2Z, b: OPD_QZ,  neg: 1'b0, first: 1'b0, wr: WR_NT};
            5'd24: u = '{a: OPD_T,   b: OPD_DX,  neg: 1'b0, first: 1'b1, wr: WR_PX};
            5'd25: u = '{a: OPD_T,   b: OPD_DY,  neg: 1'b0, first: 1'b1, wr: WR_PY};
            5'd26: u = '{a: OPD_T,   b: OPD_DZ,  neg: 1'b0, first: 1'b1, wr: WR_PZ};
            default: u = '{a: OPD_DX, b: OPD_DX, neg: 1'b0, first: 1'b1, wr: WR_NONE};
        endcase
        return u;
    endfunction

    // clamp an accumulator value to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}}))
            r = 32'sh7FFF_FFFF;
        else if (x < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}}))
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // saturating difference of two signed 32 bit values
    function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [31:0] r;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
            r = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = d[31:0];
        return r;
    endfunction

endpackage

[hdl/rmch_div.sv]
// rmch_div: restoring divider, one quotient bit per cycle, 31 bit quotient
// of (num * 2^16) / den; caller guarantees the quotient fits; uses rmch_pkg
module rmch_div
    import rmch_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ACC_W-1:0]      i_num,
    input  logic [ACC_W-1:0]      i_den,
    output logic                  o_done,
    output logic [30:0]           o_quo
);

    logic [ACC_W:0]   r_rem;
    logic [ACC_W-1:0] r_den;
    logic [30:0]      r_nb;
    logic [30:0]      r_quo;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [ACC_W:0]   n_tr;
    logic             n_ge;

    // trial subtract of the shifted remainder
    always_comb begin
        n_tr = {r_rem[ACC_W-1:0], r_nb[30]};
        n_ge = n_tr >= {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {16'd0, i_num[ACC_W-1:15]};
            r_nb  <= {i_num[14:0], 16'd0};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_tr - {1'b0, r_den}) : n_tr;
            r_nb  <= {r_nb[29:0], 1'b0};
            r_quo <= {r_quo[29:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hdl/ray_mesh_closest_hit.sv]
// ray_mesh_closest_hit: nearest ray/triangle hit over a triangle stream, Q16.16
// uses rmch_pkg and rmch_div
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------
//  triangle | in        | i_in_valid / o_in_stall | v0..v2 xyz, last
//  result   | out       | o_out_valid / i_out_stall| hit flag, distance, index, point
//  config   | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// for each triangle one 32x32 multiplier runs 24 products in turn; a triangle
// that passes the range tests then goes through the restoring divider unless
// its distance saturates; the last triangle adds the hit point products and
// the result beat, and only the result beat when nothing was hit
// synchronous active-low reset; no clearing pass
// the triangle side stalls while a triangle is in work or a result waits in S_EMIT
module ray_mesh_closest_hit
    import rmch_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_v0_x,
    input  logic signed [31:0] i_v0_y,
    input  logic signed [31:0] i_v0_z,
    input  logic signed [31:0] i_v1_x,
    input  logic signed [31:0] i_v1_y,
    input  logic signed [31:0] i_v1_z,
    input  logic signed [31:0] i_v2_x,
    input  logic signed [31:0] i_v2_y,
    input  logic signed [31:0] i_v2_z,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit_found,
    output logic [30:0]        o_hit_distance,
    output logic [15:0]        o_hit_index,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_DRAIN = 8'b0000_0100,
        S_TEST  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_PNT   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic [30:0]        r_eps, r_tmin;

    // triangle operands and intermediate vectors
    logic signed [31:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z, r_sx, r_sy, r_sz;
    logic signed [31:0] r_hx, r_hy, r_hz, r_qx, r_qy, r_qz;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [ACC_W-1:0] r_det, r_nu, r_nv, r_nt;
    logic               r_last;

    // multiplier and accumulator pipe
    logic [4:0]         r_step;
    logic               r_pv;
    t_uop               r_pop;
    logic signed [63:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // candidate and best hit
    logic               r_hit;
    logic [30:0]        r_t;
    logic               r_any;
    logic [30:0]        r_best_t;
    logic [15:0]        r_best_idx;
    logic [15:0]        r_cnt;

    // result register
    logic               r_ov;

    logic               div_start;
    logic               div_done;
    logic [30:0]        div_quo;

    logic               in_take;
    logic               out_take;
    t_uop               uop;
    logic signed [31:0] opa, opb;
    logic signed [ACC_W-1:0] term, n_acc, pnt_o;

    logic signed [ACC_W-1:0] n_det, n_nu, n_nv, n_nt;
    logic signed [ACC_W:0]   n_uv;
    logic               n_ok;
    logic               n_ovf;
    logic               n_accept;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_ov && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_oz <= '0;
            r_dx <= '0; r_dy <= '0; r_dz <= 32'sd65536;
            r_eps <= 31'd1; r_tmin <= 31'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:    r_ox   <= i_cfg_data;
                CFG_ORIGIN_Y:    r_oy   <= i_cfg_data;
                CFG_ORIGIN_Z:    r_oz   <= i_cfg_data;
                CFG_DIR_X:       r_dx   <= i_cfg_data;
                CFG_DIR_Y:       r_dy   <= i_cfg_data;
                CFG_DIR_Z:       r_dz   <= i_cfg_data;
                CFG_DET_EPSILON: r_eps  <= i_cfg_data[30:0];
                CFG_T_MIN:       r_tmin <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    function automatic logic signed [31:0] pick(input t_opd c,
        input logic signed [31:0] dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z,
        input logic signed [31:0] sx, sy, sz, hx, hy, hz, qx, qy, qz,
        input logic [30:0] t);
        logic signed [31:0] v;
        case (c)
            OPD_DX:  v = dx;
            OPD_DY:  v = dy;
            OPD_DZ:  v = dz;
            OPD_E1X: v = e1x;
            OPD_E1Y: v = e1y;
            OPD_E1Z: v = e1z;
            OPD_E2X: v = e2x;
            OPD_E2Y: v = e2y;
            OPD_E2Z: v = e2z;
            OPD_SX:  v = sx;
            OPD_SY:  v = sy;
            OPD_SZ:  v = sz;
            OPD_HX:  v = hx;
            OPD_HY:  v = hy;
            OPD_HZ:  v = hz;
            OPD_QX:  v = qx;
            OPD_QY:  v = qy;
            OPD_QZ:  v = qz;
            OPD_T:   v = {1'b0, t};
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        uop = ucode(r_step);
        opa = pick(uop.a, r_dx, r_dy, r_dz, r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z,
                   r_sx, r_sy, r_sz, r_hx, r_hy, r_hz, r_qx, r_qy, r_qz, r_best_t);
        opb = pick(uop.b, r_dx, r_dy, r_dz, r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z,
                   r_sx, r_sy, r_sz, r_hx, r_hy, r_hz, r_qx, r_qy, r_qz, r_best_t);
    end

    // accumulate stage: floored product, add or subtract
    always_comb begin
        term  = ACC_W'(r_prod >>> 16);
        if (r_pop.neg)
            term = -term;
        n_acc = (r_pop.first ? '0 : r_acc) + term;
        case (r_pop.wr)
            WR_PX:   pnt_o = ACC_W'(r_ox);
            WR_PY:   pnt_o = ACC_W'(r_oy);
            WR_PZ:   pnt_o = ACC_W'(r_oz);
            default: pnt_o = '0;
        endcase
    end

    // multiply and writeback
    always_ff @(posedge i_clk) begin
        r_prod <= opa * opb;
        r_pop  <= uop;
        if (r_pv) begin
            r_acc <= n_acc;
            case (r_pop.wr)
                WR_HX:  r_hx  <= sat32(n_acc);
                WR_HY:  r_hy  <= sat32(n_acc);
                WR_HZ:  r_hz  <= sat32(n_acc);
                WR_QX:  r_qx  <= sat32(n_acc);
                WR_QY:  r_qy  <= sat32(n_acc);
                WR_QZ:  r_qz  <= sat32(n_acc);
                WR_DET: r_det <= n_acc;
                WR_NU:  r_nu  <= n_acc;
                WR_NV:  r_nv  <= n_acc;
                WR_NT:  r_nt  <= n_acc;
                WR_PX:  r_px  <= sat32(n_acc + pnt_o);
                WR_PY:  r_py  <= sat32(n_acc + pnt_o);
                WR_PZ:  r_pz  <= sat32(n_acc + pnt_o);
                default: ;
            endcase
        end
    end

    // triangle capture: edges and origin offset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_e1x <= sat_sub32(i_v1_x, i_v0_x);
            r_e1y <= sat_sub32(i_v1_y, i_v0_y);
            r_e1z <= sat_sub32(i_v1_z, i_v0_z);
            r_e2x <= sat_sub32(i_v2_x, i_v0_x);
            r_e2y <= sat_sub32(i_v2_y, i_v0_y);
            r_e2z <= sat_sub32(i_v2_z, i_v0_z);
            r_sx  <= sat_sub32(r_ox, i_v0_x);
            r_sy  <= sat_sub32(r_oy, i_v0_y);
            r_sz  <= sat_sub32(r_oz, i_v0_z);
            r_last <= i_last;
        end
    end

    // sign fold and range tests
    always_comb begin
        if (r_det < 0) begin
            n_det = -r_det; n_nu = -r_nu; n_nv = -r_nv; n_nt = -r_nt;
        end else begin
            n_det = r_det;  n_nu = r_nu;  n_nv = r_nv;  n_nt = r_nt;
        end
        n_uv  = {n_nu[ACC_W-1], n_nu} + {n_nv[ACC_W-1], n_nv};
        n_ok  = (n_det > $signed({{(ACC_W-31){1'b0}}, r_eps})) &&
                (n_nu >= 0) && (n_nu <= n_det) && (n_nv >= 0) &&
                (n_uv <= {n_det[ACC_W-1], n_det}) && (n_nt >= 0);
        n_ovf = {15'd0, n_nt} >= {n_det, 15'd0};
        n_accept = r_hit && (r_t >= r_tmin);
    end

    assign div_start = (r_state == S_TEST) && n_ok && !n_ovf;

    rmch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_nt),
        .i_den   (n_det),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_pv       <= 1'b0;
            r_hit      <= 1'b0;
            r_t        <= '0;
            r_any      <= 1'b0;
            r_best_t   <= '0;
            r_best_idx <= '0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            if (out_take)
                r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pv <= 1'b1;
                    if (r_step == STEP_TRI_LAST || r_step == STEP_PNT_LAST)
                        r_state <= S_DRAIN;
                    else
                        r_step <= r_step + 5'd1;
                end
                S_DRAIN: begin
                    r_state <= (r_step == STEP_TRI_LAST) ? S_TEST : S_EMIT;
                end
                S_TEST: begin
                    r_hit <= 1'b0;
                    if (n_ok && n_ovf) begin
                        r_hit   <= 1'b1;
                        r_t     <= T_SAT;
                        r_state <= S_UPD;
                    end else if (n_ok) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_hit   <= 1'b1;
                        r_t     <= div_quo;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (n_accept && (!r_any || r_t < r_best_t)) begin
                        r_any      <= 1'b1;
                        r_best_t   <= r_t;
                        r_best_idx <= r_cnt;
                    end
                    if (r_cnt < IDX_CAP)
                        r_cnt <= r_cnt + 16'd1;
                    r_state <= r_last ? S_PNT : S_IDLE;
                end
                S_PNT: begin
                    if (r_any) begin
                        r_step  <= STEP_PNT_FIRST;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov       <= 1'b1;
                        r_any      <= 1'b0;
                        r_best_t   <= '0;
                        r_best_idx <= '0;
                        r_cnt      <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (!r_ov || !i_out_stall)) begin
            o_hit_found    <= r_any;
            o_hit_distance <= r_any ? r_best_t   : '0;
            o_hit_index    <= r_any ? r_best_idx : '0;
            o_point_x      <= r_any ? r_px : '0;
            o_point_y      <= r_any ? r_py : '0;
            o_point_z      <= r_any ? r_pz : '0;
        end
    end

    assign o_out_valid = r_ov;

`ifndef SYNTH
    // best hit registers stay clear while no hit is held
    a_best_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_best_t == '0 && r_best_idx == '0))
        else $error("best hit not clear without a hit");

    // a result with no hit carries zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit_found) |-> (o_hit_distance == '0 && o_hit_index == '0 &&
        o_point_x == '0 && o_point_y == '0 && o_point_z == '0))
        else $error("miss result with nonzero fields");

    // a new result only comes out of the emit state
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    // the step counter never runs past the point steps
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_step <= STEP_PNT_LAST))
        else $error("step out of range");
`endif

endmodule

[tb/sv/ray_mesh_closest_hit_chk.sv]
// ray_mesh_closest_hit_chk: watches the config, triangle and result channels of the block,
// predicts each result in Q16.16 fixed point and compares it field by field
// depends on rmch_pkg for the register index codes and the index cap
module ray_mesh_closest_hit_chk
    import rmch_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_v0_x,
    input  logic signed [31:0] i_v0_y,
    input  logic signed [31:0] i_v0_z,
    input  logic signed [31:0] i_v1_x,
    input  logic signed [31:0] i_v1_y,
    input  logic signed [31:0] i_v1_z,
    input  logic signed [31:0] i_v2_x,
    input  logic signed [31:0] i_v2_y,
    input  logic signed [31:0] i_v2_z,
    input  logic               i_last,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_hit_found,
    input  logic [30:0]        i_hit_distance,
    input  logic [15:0]        i_hit_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output int                 o_fail,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        found;
        logic [30:0] t_dist;
        logic [15:0] idx;
        logic [31:0] pnt [3];
    } t_hit;

    // mirrored registers and search state
    longint      ray_org [3];
    longint      ray_dir [3];
    longint      det_eps;
    longint      t_floor;
    logic [30:0] near_t;
    logic [15:0] near_idx;
    logic        seen_hit;
    logic [15:0] tri_count;
    t_hit        hit_q [$];

    function automatic longint fl16(input longint x);
        return x >>> 16;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic void cross3(input longint a [3], input longint b [3],
                                   output longint r [3]);
        r[0] = clamp32(fl16(a[1] * b[2]) - fl16(a[2] * b[1]));
        r[1] = clamp32(fl16(a[2] * b[0]) - fl16(a[0] * b[2]));
        r[2] = clamp32(fl16(a[0] * b[1]) - fl16(a[1] * b[0]));
    endfunction

    function automatic longint dot3(input longint a [3], input longint b [3]);
        return fl16(a[0] * b[0]) + fl16(a[1] * b[1]) + fl16(a[2] * b[2]);
    endfunction

    // moller-trumbore test of one triangle, returns hit flag and distance
    function automatic logic tri_hit(input longint v0 [3], input longint v1 [3],
                                     input longint v2 [3], output logic [30:0] t_out);
        longint   e1 [3], e2 [3], s [3], h [3], q [3];
        longint   det, nu, nv, nt;
        bit [63:0] ud, qi, rem, tv;
        t_out = '0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = clamp32(v1[i] - v0[i]);
            e2[i] = clamp32(v2[i] - v0[i]);
            s[i]  = clamp32(ray_org[i] - v0[i]);
        end
        cross3(ray_dir, e2, h);
        det = dot3(e1, h);
        if (det <= det_eps && det >= -det_eps) return 1'b0;
        nu = dot3(s, h);
        cross3(s, e1, q);
        nv = dot3(ray_dir, q);
        nt = dot3(e2, q);
        if (det < 0) begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        if (!(nu >= 0 && nu <= det && nv >= 0 && nu + nv <= det && nt >= 0)) return 1'b0;
        ud  = det;
        qi  = 64'(nt) / ud;
        rem = 64'(nt) % ud;
        if (qi >= 64'd32768) begin
            tv = 64'h7FFF_FFFF;
        end else begin
            tv = (qi << 16) + ((rem << 16) / ud);
            if (tv > 64'h7FFF_FFFF) tv = 64'h7FFF_FFFF;
        end
        if (longint'(tv) < t_floor) return 1'b0;
        t_out = tv[30:0];
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        o_fail++;
    endtask

    initial begin
        o_fail = 0;
    end

    assign o_pending = hit_q.size();

    always @(posedge i_clk) begin
        longint      va [3], vb [3], vc [3];
        logic [30:0] t_new;
        logic        hit;
        t_hit        exp_hit, got_hit;
        if (!i_rst_n) begin
            foreach (ray_org[i]) ray_org[i] = 0;
            ray_dir[0] = 0;
            ray_dir[1] = 0;
            ray_dir[2] = 65536;
            det_eps    = 1;
            t_floor    = 1;
            near_t     = '0;
            near_idx   = '0;
            seen_hit   = 1'b0;
            tri_count  = '0;
            hit_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORIGIN_X:    ray_org[0] = longint'($signed(i_cfg_data));
                    CFG_ORIGIN_Y:    ray_org[1] = longint'($signed(i_cfg_data));
                    CFG_ORIGIN_Z:    ray_org[2] = longint'($signed(i_cfg_data));
                    CFG_DIR_X:       ray_dir[0] = longint'($signed(i_cfg_data));
                    CFG_DIR_Y:       ray_dir[1] = longint'($signed(i_cfg_data));
                    CFG_DIR_Z:       ray_dir[2] = longint'($signed(i_cfg_data));
                    CFG_DET_EPSILON: det_eps    = longint'({1'b0, i_cfg_data[30:0]});
                    CFG_T_MIN:       t_floor    = longint'({1'b0, i_cfg_data[30:0]});
                    default: ;
                endcase
            end
            // triangle beat
            if (i_in_valid && !i_in_stall) begin
                va = '{i_v0_x, i_v0_y, i_v0_z};
                vb = '{i_v1_x, i_v1_y, i_v1_z};
                vc = '{i_v2_x, i_v2_y, i_v2_z};
                hit = tri_hit(va, vb, vc, t_new);
                if (hit && (!seen_hit || t_new < near_t)) begin
                    seen_hit = 1'b1;
                    near_t   = t_new;
                    near_idx = tri_count;
                end
                if (tri_count < IDX_CAP) tri_count++;
                if (i_last) begin
                    exp_hit.found  = seen_hit;
                    exp_hit.t_dist = seen_hit ? near_t : '0;
                    exp_hit.idx    = seen_hit ? near_idx : '0;
                    for (int i = 0; i < 3; i++)
                        exp_hit.pnt[i] = seen_hit ? 32'(clamp32(ray_org[i] +
                            fl16(longint'({1'b0, near_t}) * ray_dir[i]))) : '0;
                    hit_q.push_back(exp_hit);
                    near_t    = '0;
                    near_idx  = '0;
                    seen_hit  = 1'b0;
                    tri_count = '0;
                end
            end
            // result beat
            if (i_out_valid && !i_out_stall) begin
                if (hit_q.size() == 0) begin
                    $display("%0t unexpected result beat", $realtime);
                    o_fail++;
                end else begin
                    exp_hit = hit_q.pop_front();
                    got_hit.pnt = '{i_point_x, i_point_y, i_point_z};
                    if (i_hit_found !== exp_hit.found)
                        report("hit_found", 32'(i_hit_found), 32'(exp_hit.found));
                    if (i_hit_distance !== exp_hit.t_dist)
                        report("hit_distance", 32'(i_hit_distance), 32'(exp_hit.t_dist));
                    if (i_hit_index !== exp_hit.idx)
                        report("hit_index", 32'(i_hit_index), 32'(exp_hit.idx));
                    for (int i = 0; i < 3; i++)
                        if (got_hit.pnt[i] !== exp_hit.pnt[i])
                            report($sformatf("point[%0d]", i), got_hit.pnt[i], exp_hit.pnt[i]);
                end
            end
        end
    end

endmodule

[tb/sv/ray_mesh_closest_hit_tb.sv]
// ray_mesh_closest_hit_tb: top of the closest-hit testbench; drives registers, triangle
// meshes and result back-pressure, and gives the verdict
// depends on rmch_pkg, ray_mesh_closest_hit and ray_mesh_closest_hit_chk
module ray_mesh_closest_hit_tb;
    import rmch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] vtx [9];
    logic               i_last;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_hit_found;
    logic [30:0]        o_hit_distance;
    logic [15:0]        o_hit_index;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    int                 fail_count;
    int                 pending;

    // ray as last written, for aiming triangles
    longint aim_org [3];
    longint aim_dir [3];

    ray_mesh_closest_hit uut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .o_in_stall,
        .i_v0_x(vtx[0]), .i_v0_y(vtx[1]), .i_v0_z(vtx[2]),
        .i_v1_x(vtx[3]), .i_v1_y(vtx[4]), .i_v1_z(vtx[5]),
        .i_v2_x(vtx[6]), .i_v2_y(vtx[7]), .i_v2_z(vtx[8]),
        .i_last, .o_out_valid, .i_out_stall,
        .o_hit_found, .o_hit_distance, .o_hit_index, .o_point_x, .o_point_y, .o_point_z
    );

    ray_mesh_closest_hit_chk chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall),
        .i_v0_x(vtx[0]), .i_v0_y(vtx[1]), .i_v0_z(vtx[2]),
        .i_v1_x(vtx[3]), .i_v1_y(vtx[4]), .i_v1_z(vtx[5]),
        .i_v2_x(vtx[6]), .i_v2_y(vtx[7]), .i_v2_z(vtx[8]),
        .i_last, .i_out_valid(o_out_valid), .i_out_stall,
        .i_hit_found(o_hit_found), .i_hit_distance(o_hit_distance),
        .i_hit_index(o_hit_index), .i_point_x(o_point_x), .i_point_y(o_point_y),
        .i_point_z(o_point_z), .o_fail(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // run limit
    initial begin
        #8ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result back-pressure, with one long hold-off so the block fills up
    initial begin
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        n = 0;
        forever begin
            n++;
            if (n == 30) begin
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_stall <= ($urandom_range(0, 3) != 0);
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx <= CFG_ORIGIN_Z) aim_org[idx] = longint'($signed(data));
        else if (idx <= CFG_DIR_Z) aim_dir[idx - CFG_DIR_X] = longint'($signed(data));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one triangle beat, held until taken, then an optional gap
    task automatic send_tri(input logic [31:0] v [9], input logic lst);
        int g;
        i_in_valid <= 1'b1;
        i_last     <= lst;
        for (int i = 0; i < 9; i++) vtx[i] <= v[i];
        do @(posedge i_clk); while (o_in_stall);
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // triangle with its centroid on the ray, sometimes pushed off it
    function automatic void aimed_tri(output logic [31:0] v [9]);
        longint c [3], p [3], q [3];
        longint k;
        int     span;
        k    = $urandom_range(0, 20 * 65536);
        span = 1 << $urandom_range(10, 19);
        for (int i = 0; i < 3; i++) begin
            c[i] = aim_org[i] + ((k * aim_dir[i]) >>> 16);
            if ($urandom_range(0, 4) == 0) c[i] += $signed($urandom_range(0, 2 * span)) - span;
            p[i] = $signed($urandom_range(0, 2 * span)) - span;
            q[i] = $signed($urandom_range(0, 2 * span)) - span;
            v[i]     = 32'(c[i] - p[i] - q[i]);
            v[3 + i] = 32'(c[i] + 2 * p[i] - q[i]);
            v[6 + i] = 32'(c[i] - p[i] + 2 * q[i]);
        end
    endfunction

    // stop offering beats and wait for the block to drain
    task automatic settle();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] v [9];
        logic [31:0] one;
        int          items;
        int          len;
        one = 32'h0001_0000;
        aim_org = '{0, 0, 0};
        aim_dir = '{0, 0, 65536};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ORIGIN_X;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_last = 1'b0;
        foreach (vtx[i]) vtx[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: hit in front, same triangle again (first wins), behind, parallel
        v = '{-one, -one, 5 * one, one, -one, 5 * one, -one, one, 5 * one};
        send_tri(v, 1'b0);
        send_tri(v, 1'b0);
        v = '{-one, -one, -3 * one, one, -one, -3 * one, -one, one, -3 * one};
        send_tri(v, 1'b0);
        v = '{0, 0, 0, one, 0, one, 0, 0, 2 * one};
        send_tri(v, 1'b1);
        // nearer hit later in the mesh, then a mesh with no hit at all
        v = '{-one, -one, 9 * one, one, -one, 9 * one, -one, one, 9 * one};
        send_tri(v, 1'b0);
        v = '{-one, -one, 2 * one, one, -one, 2 * one, -one, one, 2 * one};
        send_tri(v, 1'b1);
        v = '{5 * one, 5 * one, one, 6 * one, 5 * one, one, 5 * one, 6 * one, one};
        send_tri(v, 1'b1);
        // extreme vertex values
        v = '{9{32'h8000_0000}};
        send_tri(v, 1'b0);
        v = '{9{32'h7FFF_FFFF}};
        send_tri(v, 1'b0);
        v = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_tri(v, 1'b0);
        v = '{9{32'hFFFF_FFFF}};
        send_tri(v, 1'b1);
        settle();
        // far hit: tiny direction, t saturates; zero t_min and epsilon
        cfg_write(CFG_DIR_Z, 32'd1);
        cfg_write(CFG_T_MIN, 32'd0);
        cfg_write(CFG_DET_EPSILON, 32'd0);
        v = '{-one, -one, 20000 * one, one, -one, 20000 * one, -one, one, 20000 * one};
        send_tri(v, 1'b1);
        v = '{-one, -one, 0, one, -one, 0, -one, one, 0};
        send_tri(v, 1'b1);
        settle();

        // random phases over a range of register settings
        items = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    for (int i = 0; i < 3; i++)
                        cfg_write(t_cfg_idx'(i), $signed($urandom_range(0, 1 << 22)) - (1 << 21));
                    for (int i = 3; i < 6; i++)
                        cfg_write(t_cfg_idx'(i), $signed($urandom_range(0, 1 << 18)) - (1 << 17));
                    cfg_write(CFG_DET_EPSILON, $urandom_range(0, 1 << $urandom_range(0, 12)));
                    cfg_write(CFG_T_MIN, $urandom_range(0, 1 << 16));
                end
                1: begin
                    cfg_write(CFG_ORIGIN_X, 32'h7FFF_FFFF);
                    cfg_write(CFG_ORIGIN_Y, 32'h8000_0000);
                    cfg_write(CFG_ORIGIN_Z, $urandom());
                    cfg_write(CFG_DIR_X, 32'h8000_0000);
                    cfg_write(CFG_DIR_Y, 32'h7FFF_FFFF);
                    cfg_write(CFG_DIR_Z, $urandom());
                    cfg_write(CFG_DET_EPSILON, 32'd0);
                    cfg_write(CFG_T_MIN, 32'd0);
                end
                2: begin
                    for (int i = 0; i < 6; i++) cfg_write(t_cfg_idx'(i), $urandom());
                    cfg_write(CFG_DET_EPSILON, 32'h7FFF_FFFF);
                    cfg_write(CFG_T_MIN, $urandom());
                end
                default: begin
                    for (int i = 0; i < 3; i++)
                        cfg_write(t_cfg_idx'(i), $signed($urandom_range(0, 1 << 20)) - (1 << 19));
                    for (int i = 3; i < 6; i++)
                        cfg_write(t_cfg_idx'(i), $signed($urandom_range(0, 1 << 17)) - (1 << 16));
                    cfg_write(CFG_DET_EPSILON, 32'd1);
                    cfg_write(CFG_T_MIN, (ph == 7) ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 18));
                end
            endcase
            while (items < 66 * (ph + 1)) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        foreach (v[i]) v[i] = $urandom();
                    else
                        aimed_tri(v);
                    send_tri(v, k == len - 1);
                    items++;
                end
            end
            settle();
        end

        i_in_valid <= 1'b0;
        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
